FILE: src/rtid_pkg.sv
`default_nettype none
package rtid_pkg;

  localparam int WORD_W   = 32;
  localparam int CFG_W    = 3;
  localparam int IN_WORDS = 4;
  localparam logic [CFG_W-1:0] COLS_RESET = 3'd4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_GATHER
  } fsm_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: src/rtid_in_if.sv
`default_nettype none
interface rtid_in_if import rtid_pkg::*; #(
  parameter int PW = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [PW-1:0]            position;
  logic signed [WORD_W-1:0] row_word_0;
  logic signed [WORD_W-1:0] row_word_1;
  logic signed [WORD_W-1:0] row_word_2;
  logic signed [WORD_W-1:0] row_word_3;

  modport source (output valid, op, position, row_word_0, row_word_1, row_word_2,
                  row_word_3, input ready);
  modport sink (input valid, op, position, row_word_0, row_word_1, row_word_2,
                row_word_3, output ready);
endinterface
`default_nettype wire

FILE: src/rtid_out_if.sv
`default_nettype none
interface rtid_out_if import rtid_pkg::*; #(
  parameter int PW = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [PW-1:0]            count_after;
  logic signed [WORD_W-1:0] read_word_0;
  logic signed [WORD_W-1:0] read_word_1;
  logic signed [WORD_W-1:0] read_word_2;
  logic signed [WORD_W-1:0] read_word_3;

  modport source (output valid, status, count_after, read_word_0, read_word_1,
                  read_word_2, read_word_3, input ready);
  modport sink (input valid, status, count_after, read_word_0, read_word_1,
                read_word_2, read_word_3, output ready);
endinterface
`default_nettype wire

FILE: src/rtid_cfg_if.sv
`default_nettype none
interface rtid_cfg_if import rtid_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: src/rtid_cell.sv
`default_nettype none
module rtid_cell import rtid_pkg::*; #(
  parameter int COLS = 4,
  parameter int PW   = 5,
  parameter int IDX  = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cell_cmd_t                   cmd,
  input  wire logic [PW-1:0]               pos,
  input  wire logic [PW-1:0]               count,
  input  wire logic [COLS-1:0]             col_en,
  input  wire logic [COLS-1:0][WORD_W-1:0] new_row,
  input  wire logic [COLS-1:0][WORD_W-1:0] prev_row,
  input  wire logic [COLS-1:0][WORD_W-1:0] next_row,
  output logic      [COLS-1:0][WORD_W-1:0] row_o,
  output logic      [COLS-1:0][WORD_W-1:0] rd_o
);

  localparam logic [PW:0] MY = (PW+1)'(IDX);

  logic [COLS-1:0][WORD_W-1:0] row_r, row_nxt;
  logic [COLS-1:0][WORD_W-1:0] rd_r, rd_nxt;
  logic [PW:0] pos_x, cnt_x;
  logic take_prev, take_new, take_next, hit;

  always_comb begin
    pos_x     = {1'b0, pos};
    cnt_x     = {1'b0, count};
    hit       = (MY == pos_x);
    take_new  = cmd.ins && hit;
    take_prev = cmd.ins && (MY > pos_x) && (MY <= cnt_x);
    take_next = cmd.del && (MY >= pos_x) && ((MY + 1'b1) < cnt_x);
    row_nxt   = row_r;
    for (int j = 0; j < COLS; j++) begin
      if (col_en[j]) begin
        if (take_new) begin
          row_nxt[j] = new_row[j];
        end else if (take_prev) begin
          row_nxt[j] = prev_row[j];
        end else if (take_next) begin
          row_nxt[j] = next_row[j];
        end
      end
    end
    for (int j = 0; j < COLS; j++) begin
      rd_nxt[j] = (cmd.rd && hit && col_en[j]) ? row_r[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      rd_r  <= '0;
    end else begin
      row_r <= row_nxt;
      rd_r  <= rd_nxt;
    end
  end

  assign row_o = row_r;
  assign rd_o  = rd_r;

endmodule
`default_nettype wire

FILE: src/row_table_insert_delete.sv
`default_nettype none
// Ordered table of ROWS rows of COLS signed 32-bit words held in a chain of
// row cells. Insert (op 0) places a row at a position from 0 to the count and
// every later cell takes its upper neighbor's row; delete (op 1) has the cell
// there and every later cell take its lower neighbor's row; read (op 2)
// returns one row. Each request returns one response with a status (0 done,
// 1 full, 2 bad position) and the row count after the request. The cells
// shift and latch their read slice on the accept edge, and the next cycle
// merges the read slices of all rows into the output register. A new request
// is taken while a response waits, as long as the output register drains in
// the same cycle. Only the first columns_in_use words (capped at COLS) move,
// are written or are read; write the cfg port only while idle.
module row_table_insert_delete import rtid_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rtid_in_if.sink     in_req,
  rtid_out_if.source  out_rsp,
  rtid_cfg_if.sink    cfg_wr
);

  localparam int PW = $clog2(ROWS + 1);
  localparam int CW = (COLS > 7) ? 4 : 3;

  fsm_t state_r, state_nxt;
  logic [CFG_W-1:0] cols_r;
  logic [PW-1:0]    count_r, count_nxt;
  logic [1:0]       pend_status_r, pend_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [PW-1:0]    out_count_r, out_count_nxt;
  logic [IN_WORDS-1:0][WORD_W-1:0] out_words_r, out_words_nxt;

  logic accept;
  cell_cmd_t cmd;
  logic [COLS-1:0] col_en;
  logic [CW-1:0] ncols;
  logic [COLS-1:0][WORD_W-1:0] new_row;
  logic [COLS-1:0][WORD_W-1:0] rows   [ROWS];
  logic [COLS-1:0][WORD_W-1:0] rds    [ROWS];
  logic [COLS-1:0][WORD_W-1:0] rd_any;
  logic full;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
    end else if (cfg_wr.valid) begin
      cols_r <= cfg_wr.data;
    end
  end

  always_comb begin
    ncols = (CW'(cols_r) > CW'(COLS)) ? CW'(COLS) : CW'(cols_r);
    for (int j = 0; j < COLS; j++) begin
      col_en[j] = (CW'(j) < ncols);
    end
    for (int j = 0; j < COLS; j++) begin
      new_row[j] = '0;
    end
    new_row[0] = in_req.row_word_0;
    if (COLS > 1) new_row[1 % COLS] = in_req.row_word_1;
    if (COLS > 2) new_row[2 % COLS] = in_req.row_word_2;
    if (COLS > 3) new_row[3 % COLS] = in_req.row_word_3;
  end

  assign in_req.ready = (state_r == FSM_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign full         = ({1'b0, count_r} == (PW+1)'(ROWS));

  always_comb begin
    cmd             = '0;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    if (accept) begin
      case (op_t'(in_req.op))
        OP_INSERT: begin
          if (full) begin
            pend_status_nxt = ST_FULL;
          end else if (in_req.position > count_r) begin
            pend_status_nxt = ST_BAD_POS;
          end else begin
            pend_status_nxt = ST_DONE;
            cmd.ins         = 1'b1;
            count_nxt       = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (in_req.position >= count_r) begin
            pend_status_nxt = ST_BAD_POS;
          end else begin
            pend_status_nxt = ST_DONE;
            cmd.del         = 1'b1;
            count_nxt       = count_r - 1'b1;
          end
        end
        OP_READ: begin
          if (in_req.position >= count_r) begin
            pend_status_nxt = ST_BAD_POS;
          end else begin
            pend_status_nxt = ST_DONE;
            cmd.rd          = 1'b1;
          end
        end
        default: begin
          pend_status_nxt = ST_BAD_POS;
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < ROWS; g++) begin : g_cell
      rtid_cell #(.COLS(COLS), .PW(PW), .IDX(g)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pos      (in_req.position),
        .count    (count_r),
        .col_en   (col_en),
        .new_row  (new_row),
        .prev_row ((g == 0) ? '0 : rows[(g + ROWS - 1) % ROWS]),
        .next_row ((g == ROWS - 1) ? '0 : rows[(g + 1) % ROWS]),
        .row_o    (rows[g]),
        .rd_o     (rds[g])
      );
    end
  endgenerate

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < ROWS; i++) begin
      rd_any = rd_any | rds[i];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_words_nxt  = out_words_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = FSM_GATHER;
        end
      end
      FSM_GATHER: begin
        state_nxt      = FSM_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = pend_status_r;
        out_count_nxt  = count_r;
        for (int j = 0; j < IN_WORDS; j++) begin
          out_words_nxt[j] = (j < COLS) ? rd_any[j % COLS] : '0;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_words_r   <= out_words_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.count_after = out_count_r;
  assign out_rsp.read_word_0 = out_words_r[0];
  assign out_rsp.read_word_1 = out_words_r[1];
  assign out_rsp.read_word_2 = out_words_r[2];
  assign out_rsp.read_word_3 = out_words_r[3];

endmodule
`default_nettype wire
